// File: rtl/tiew_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tiew_pkg;
  localparam int unsigned AddStations = 3;
  localparam int unsigned MulStations = 2;
  localparam int unsigned RegCount = 5;
  localparam int unsigned DataWidth = 32;

  localparam logic [2:0] MODE_ADD  = 3'd0;
  localparam logic [2:0] MODE_ADDI = 3'd1;
  localparam logic [2:0] MODE_SUB  = 3'd2;
  localparam logic [2:0] MODE_MUL  = 3'd3;
  localparam logic [2:0] MODE_DIV  = 3'd4;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  typedef struct packed {
    logic       issue_valid;
    logic [2:0] mode;
    logic [2:0] dest_reg;
    logic [2:0] src1_reg;
    logic [2:0] src2_reg;
    logic signed [31:0] immediate;
  } req_t;

  typedef struct packed {
    logic       issued;
    logic       add_wb_valid;
    logic [1:0] add_wb_station;
    logic [2:0] add_wb_dest;
    logic signed [31:0] add_wb_value;
    logic       mul_wb_valid;
    logic       mul_wb_station;
    logic [2:0] mul_wb_dest;
    logic signed [31:0] mul_wb_value;
    logic       div_by_zero;
    logic       idle;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;      // take request, do writeback phase
    logic exec;      // run execute scan step for current station
    logic div_start;
    logic div_step;
    logic div_done;  // finish the division of the current station
    logic issue;     // issue phase and output capture
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_div;  // current scan station is ready and is a divide
    logic scan_last;
    logic div_last;
  } sts_t;
endpackage
`default_nettype wire

// File: rtl/tiew_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface tiew_req_if;
  logic valid;
  logic ready;
  tiew_pkg::req_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface tiew_rsp_if;
  logic valid;
  logic ready;
  tiew_pkg::rsp_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/tiew_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module tiew_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  input  tiew_pkg::sts_t     sts_i,
  output tiew_pkg::cmd_t     cmd_o
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_ISS  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else begin
          cmd_o.exec = 1'b1;
          if (sts_i.scan_last) state_d = S_ISS;
        end
      end
      S_DIV: begin
        if (sts_i.div_last) begin
          cmd_o.div_done = 1'b1;
          state_d = sts_i.scan_last ? S_ISS : S_SCAN;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_ISS: begin
        cmd_o.issue = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
`default_nettype wire

// File: rtl/tiew_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module tiew_dp #(
  parameter int unsigned AddStations = tiew_pkg::AddStations,
  parameter int unsigned MulStations = tiew_pkg::MulStations,
  parameter int unsigned RegCount = tiew_pkg::RegCount,
  parameter int unsigned DataWidth = tiew_pkg::DataWidth
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  tiew_pkg::req_t  req_i,
  input  tiew_pkg::cmd_t  cmd_i,
  output tiew_pkg::sts_t  sts_o,
  output tiew_pkg::rsp_t  rsp_o
);
  localparam int unsigned NStat = AddStations + MulStations;
  localparam int unsigned TW = (NStat > 1) ? $clog2(NStat) : 1;
  localparam int unsigned RW = (RegCount > 1) ? $clog2(RegCount) : 1;
  localparam int unsigned CW = $clog2(NStat + 1);
  localparam int unsigned AW = $clog2(AddStations + 1);
  localparam int unsigned MW = $clog2(MulStations + 1);
  localparam int unsigned DCW = $clog2(DataWidth + 1);

  typedef struct packed {
    logic [TW-1:0]        st;
    logic [2:0]           dest;
    logic [DataWidth-1:0] value;
    logic                 dz;
  } entry_t;

  logic [DataWidth-1:0] regs_q [RegCount];
  logic                 ren_v_q [RegCount];
  logic [TW-1:0]        ren_t_q [RegCount];
  logic                 busy_q [NStat];
  logic                 done_q [NStat];
  logic [1:0]           op_q [NStat];
  logic [2:0]           sdest_q [NStat];
  logic                 w1_q [NStat], w2_q [NStat];
  logic [TW-1:0]        t1_q [NStat], t2_q [NStat];
  logic [DataWidth-1:0] v1_q [NStat], v2_q [NStat];
  entry_t               abuf_q [AddStations];
  entry_t               mbuf_q [MulStations];
  logic [AW-1:0]        acnt_q;
  logic [MW-1:0]        mcnt_q;
  tiew_pkg::req_t       req_q;
  tiew_pkg::rsp_t       rsp_q;
  logic [CW-1:0]        scan_q;
  logic [TW-1:0]        si;

  // divider
  logic [DataWidth-1:0] dq_q, dr_q, dd_q;
  logic [DCW-1:0]       dcnt_q;
  logic                 dneg_q;

  assign si = scan_q[TW-1:0];
  assign sts_o.scan_last = (scan_q == CW'(NStat - 1));
  assign sts_o.need_div = busy_q[si] && !done_q[si] && !w1_q[si] && !w2_q[si]
                          && op_q[si] == tiew_pkg::OP_DIV;
  assign sts_o.div_last = (dcnt_q == '0);
  assign rsp_o = rsp_q;

  function automatic logic [DataWidth-1:0] absv(input logic [DataWidth-1:0] v);
    absv = v[DataWidth-1] ? (~v + 1'b1) : v;
  endfunction

  logic [DataWidth:0]   rem_sh;
  logic [DataWidth:0]   rem_sub;
  always_comb begin
    rem_sh = {dr_q, dq_q[DataWidth-1]};
    rem_sub = rem_sh - {1'b0, dd_q};
  end

  // writeback of one entry per unit, execute, divide and issue on a snapshot of stations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    entry_t ae, me, e;
    logic av, mv, ready, dz, anyb;
    logic [DataWidth-1:0] res, a, b, q;
    logic [2:0] m;
    logic isadd, ismul, found;
    logic [TW-1:0] fs;
    tiew_pkg::rsp_t nr;
    if (!rst_ni) begin
      for (int r = 0; r < RegCount; r++) begin
        regs_q[r] <= DataWidth'(2 * r);
        ren_v_q[r] <= 1'b0;
        ren_t_q[r] <= '0;
      end
      for (int i = 0; i < NStat; i++) begin
        busy_q[i] <= 1'b0;
        done_q[i] <= 1'b0;
        w1_q[i] <= 1'b0;
        w2_q[i] <= 1'b0;
      end
      acnt_q <= '0;
      mcnt_q <= '0;
      scan_q <= '0;
      dcnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        req_q <= req_i;
        scan_q <= '0;
        av = acnt_q != '0;
        mv = mcnt_q != '0;
        ae = abuf_q[0];
        me = mbuf_q[0];
        nr = '0;
        if (av) begin
          for (int k = 0; k < AddStations - 1; k++) abuf_q[k] <= abuf_q[k+1];
          acnt_q <= acnt_q - 1'b1;
          nr.add_wb_valid = 1'b1;
          nr.add_wb_station = 2'(ae.st);
          nr.add_wb_dest = ae.dest;
          nr.add_wb_value = 32'(signed'(ae.value));
        end
        if (mv) begin
          for (int k = 0; k < MulStations - 1; k++) mbuf_q[k] <= mbuf_q[k+1];
          mcnt_q <= mcnt_q - 1'b1;
          nr.mul_wb_valid = 1'b1;
          nr.mul_wb_station = 1'(me.st - TW'(AddStations));
          nr.mul_wb_dest = me.dest;
          nr.mul_wb_value = 32'(signed'(me.value));
          nr.div_by_zero = me.dz;
        end
        rsp_q <= nr;
        for (int i = 0; i < NStat; i++) begin
          if ((av && TW'(i) == ae.st) || (mv && TW'(i) == me.st)) begin
            // writing station is freed
            busy_q[i] <= 1'b0;
            done_q[i] <= 1'b0;
            w1_q[i] <= 1'b0;
            w2_q[i] <= 1'b0;
          end else if (busy_q[i]) begin
            if ((av && w1_q[i] && t1_q[i] == ae.st) || (mv && w1_q[i] && t1_q[i] == me.st)) begin
              w1_q[i] <= 1'b0;
              v1_q[i] <= (mv && t1_q[i] == me.st) ? me.value : ae.value;
            end
            if ((av && w2_q[i] && t2_q[i] == ae.st) || (mv && w2_q[i] && t2_q[i] == me.st)) begin
              w2_q[i] <= 1'b0;
              v2_q[i] <= (mv && t2_q[i] == me.st) ? me.value : ae.value;
            end
          end
        end
        for (int r = 0; r < RegCount; r++) begin
          if (mv && me.dest == 3'(r) && ren_v_q[r] && ren_t_q[r] == me.st) begin
            regs_q[r] <= me.value;
            ren_v_q[r] <= 1'b0;
          end else if (av && ae.dest == 3'(r) && ren_v_q[r] && ren_t_q[r] == ae.st) begin
            regs_q[r] <= ae.value;
            ren_v_q[r] <= 1'b0;
          end
        end
      end

      if (cmd_i.div_start) begin
        a = v1_q[si];
        b = v2_q[si];
        dq_q <= absv(a);
        dd_q <= absv(b);
        dr_q <= '0;
        dneg_q <= a[DataWidth-1] ^ b[DataWidth-1];
        dcnt_q <= DCW'(DataWidth);
      end
      if (cmd_i.div_step) begin
        dcnt_q <= dcnt_q - 1'b1;
        if (!rem_sub[DataWidth]) begin
          dr_q <= rem_sub[DataWidth-1:0];
          dq_q <= {dq_q[DataWidth-2:0], 1'b1};
        end else begin
          dr_q <= rem_sh[DataWidth-1:0];
          dq_q <= {dq_q[DataWidth-2:0], 1'b0};
        end
      end

      if (cmd_i.exec || cmd_i.div_done) begin
        if (!sts_o.scan_last) scan_q <= scan_q + 1'b1;
        ready = busy_q[si] && !done_q[si] && !w1_q[si] && !w2_q[si];
        a = v1_q[si];
        b = v2_q[si];
        dz = 1'b0;
        case (op_q[si])
          tiew_pkg::OP_ADD: res = a + b;
          tiew_pkg::OP_SUB: res = a - b;
          tiew_pkg::OP_MUL: res = DataWidth'(a * b);
          default: begin
            dz = (dd_q == '0);
            q = dneg_q ? (~dq_q + 1'b1) : dq_q;
            res = dz ? '0 : q;
          end
        endcase
        e.st = si;
        e.dest = sdest_q[si];
        e.value = res;
        e.dz = dz;
        if (ready) begin
          done_q[si] <= 1'b1;
          if (32'(si) < AddStations) begin
            if (32'(acnt_q) < AddStations) begin
              abuf_q[acnt_q[$clog2(AddStations > 1 ? AddStations : 2)-1:0]] <= e;
              acnt_q <= acnt_q + 1'b1;
            end
          end else if (32'(mcnt_q) < MulStations) begin
            mbuf_q[mcnt_q[$clog2(MulStations > 1 ? MulStations : 2)-1:0]] <= e;
            mcnt_q <= mcnt_q + 1'b1;
          end
        end
      end

      if (cmd_i.issue) begin
        m = req_q.mode;
        nr = rsp_q;
        nr.issued = 1'b0;
        found = 1'b0;
        fs = '0;
        anyb = 1'b0;
        for (int i = 0; i < NStat; i++) anyb = anyb | busy_q[i];
        if (req_q.issue_valid) begin
          if (m > tiew_pkg::MODE_DIV) begin
            nr.issued = 1'b1;
          end else begin
            ismul = (m == tiew_pkg::MODE_MUL) || (m == tiew_pkg::MODE_DIV);
            for (int i = NStat - 1; i >= 0; i--) begin
              isadd = (i < AddStations);
              if (!busy_q[i] && (isadd != ismul)) begin
                found = 1'b1;
                fs = TW'(i);
              end
            end
            if (found) begin
              nr.issued = 1'b1;
              busy_q[fs] <= 1'b1;
              done_q[fs] <= 1'b0;
              sdest_q[fs] <= req_q.dest_reg;
              case (m)
                tiew_pkg::MODE_SUB: op_q[fs] <= tiew_pkg::OP_SUB;
                tiew_pkg::MODE_MUL: op_q[fs] <= tiew_pkg::OP_MUL;
                tiew_pkg::MODE_DIV: op_q[fs] <= tiew_pkg::OP_DIV;
                default: op_q[fs] <= tiew_pkg::OP_ADD;
              endcase
              if (32'(req_q.src1_reg) >= RegCount) begin
                w1_q[fs] <= 1'b0; t1_q[fs] <= '0; v1_q[fs] <= '0;
              end else if (ren_v_q[req_q.src1_reg[RW-1:0]]) begin
                w1_q[fs] <= 1'b1; t1_q[fs] <= ren_t_q[req_q.src1_reg[RW-1:0]];
                v1_q[fs] <= '0;
              end else begin
                w1_q[fs] <= 1'b0; t1_q[fs] <= '0;
                v1_q[fs] <= regs_q[req_q.src1_reg[RW-1:0]];
              end
              if (m == tiew_pkg::MODE_ADDI) begin
                w2_q[fs] <= 1'b0; t2_q[fs] <= '0;
                v2_q[fs] <= DataWidth'(64'(signed'(req_q.immediate)));
              end else if (32'(req_q.src2_reg) >= RegCount) begin
                w2_q[fs] <= 1'b0; t2_q[fs] <= '0; v2_q[fs] <= '0;
              end else if (ren_v_q[req_q.src2_reg[RW-1:0]]) begin
                w2_q[fs] <= 1'b1; t2_q[fs] <= ren_t_q[req_q.src2_reg[RW-1:0]];
                v2_q[fs] <= '0;
              end else begin
                w2_q[fs] <= 1'b0; t2_q[fs] <= '0;
                v2_q[fs] <= regs_q[req_q.src2_reg[RW-1:0]];
              end
              if (32'(req_q.dest_reg) < RegCount) begin
                ren_v_q[req_q.dest_reg[RW-1:0]] <= 1'b1;
                ren_t_q[req_q.dest_reg[RW-1:0]] <= fs;
              end
            end
          end
        end
        // idle reflects the state after this issue
        nr.idle = !(anyb || found) && acnt_q == '0 && mcnt_q == '0;
        rsp_q <= nr;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/tomasulo_issue_execute_writeback.sv
`timescale 1ns / 1ps
`default_nettype none
// Tomasulo issue / execute / writeback core, one request per machine cycle.
// Channels: req (sink) carries one optional instruction; rsp (source) carries
// the issue status and both units' writebacks of that cycle.
// Flow per request: a writeback step, then an execute scan over every station,
// with each station that runs a divide going through the shared radix-2
// divider, then an issue step, then the response is held.
// A new request is taken only after the response to the previous one has
// been delivered, in the cycle after that handshake.
// Reset loads register i with 2*i, clears renames, stations and buffers.
// A stalled receiver holds the response and the core waits.
module tomasulo_issue_execute_writeback #(
  parameter int unsigned AddStations = tiew_pkg::AddStations,
  parameter int unsigned MulStations = tiew_pkg::MulStations,
  parameter int unsigned RegCount = tiew_pkg::RegCount,
  parameter int unsigned DataWidth = tiew_pkg::DataWidth
) (
  input  wire clk_i,
  input  wire rst_ni,
  tiew_req_if.sink   req,
  tiew_rsp_if.source rsp
);
  tiew_pkg::cmd_t cmd;
  tiew_pkg::sts_t sts;
  tiew_pkg::rsp_t dp_rsp;

  tiew_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(req.valid), .in_ready_o(req.ready),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  tiew_dp #(
    .AddStations(AddStations), .MulStations(MulStations),
    .RegCount(RegCount), .DataWidth(DataWidth)
  ) u_dp (
    .clk_i, .rst_ni, .req_i(req.data), .cmd_i(cmd), .sts_o(sts), .rsp_o(dp_rsp)
  );

  assign rsp.data = dp_rsp;
endmodule
`default_nettype wire
